FILE: rtl/core/homogeneous_point_transform_2d_macros.svh
// Assertion macros shared by the point transform RTL.
// Depends on nothing; included by the top-level module, which checks its own logic.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_2D_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_2D_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define HPT2D_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpt2d assertion failed");

// Antecedent implies consequent in the next cycle.
`define HPT2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpt2d assertion failed");

`endif

FILE: rtl/core/hpt2d_pkg.sv
// Shared constants and types for the 2D homogeneous point transform.
// No dependencies.
package hpt2d_pkg;

    localparam int COEF_BITS  = 21;
    localparam int COORD_BITS = 16;
    localparam int COORD_FRAC = 4;
    localparam int OUT_FRAC   = 16;
    localparam int OUT_W      = 32;
    localparam int REG_W      = 63;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;
    localparam int NUM_AXES   = 3;

    localparam int PROD_W = COEF_BITS + COORD_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W;
    localparam int STEPS  = OUT_W;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_ROW_X = 2'd0;
    localparam t_reg_idx REG_ROW_Y = 2'd1;
    localparam t_reg_idx REG_ROW_W = 2'd2;

    typedef logic signed [COEF_BITS-1:0]  t_coef;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic        [MAG_W-1:0]      t_mag;
    typedef logic        [OUT_W-1:0]      t_quo;
    typedef logic        [REG_W-1:0]      t_row;

    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

FILE: rtl/core/homogeneous_point_transform_2d.sv
// Top level of the 2D homogeneous point transform: multiply, sum, divide, saturate.
// Depends on hpt2d_pkg and homogeneous_point_transform_2d_macros.svh.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one point (i_point_x, i_point_y, Q12.4).
//   Output channel (o_valid/i_ready) carries o_out_x, o_out_y (Q16.16), o_zero_divisor
//   and o_saturated. A transfer happens on a clock edge with valid and ready both high.
//   The APB port holds three 63-bit matrix rows at byte addresses 0, 8 and 16; write
//   them only while no point is in flight. Reads return the row value, pready is tied high.
// Timing:
//   One point per clock sustained while i_ready stays high. From input transfer to output
//   valid the path is one multiply stage, one sum stage, one sign/magnitude stage, 32
//   restoring divide stages (one quotient bit per stage, both axes in parallel lanes sharing
//   the divisor) and one saturating output register. The divider chain sets the latency.
// Reset:
//   Synchronous active-low reset clears every valid bit and loads the identity matrix.
// Backpressure:
//   When the output holds a result and i_ready is low, the whole pipe holds and o_ready
//   drops; nothing is dropped or repeated. Bubbles between items stay where they are.
module homogeneous_point_transform_2d (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  hpt2d_pkg::t_coord             i_point_x,
    input  hpt2d_pkg::t_coord             i_point_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [hpt2d_pkg::OUT_W-1:0] o_out_x,
    output logic signed [hpt2d_pkg::OUT_W-1:0] o_out_y,
    output logic                          o_zero_divisor,
    output logic                          o_saturated,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpt2d_pkg::ADDR_W-1:0]  paddr,
    input  logic [hpt2d_pkg::DATA_W-1:0]  pwdata,
    output logic [hpt2d_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import hpt2d_pkg::*;
`include "homogeneous_point_transform_2d_macros.svh"

    // Configuration rows
    t_row r_row_x, r_row_y, r_row_w;
    t_reg_idx cfg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= REG_W'(1) << 10;
            r_row_y <= REG_W'(1) << (10 + COEF_BITS);
            r_row_w <= REG_W'(1) << (10 + 2 * COEF_BITS);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROW_X: r_row_x <= pwdata[REG_W-1:0];
                REG_ROW_Y: r_row_y <= pwdata[REG_W-1:0];
                REG_ROW_W: r_row_w <= pwdata[REG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROW_X: prdata = {1'b0, r_row_x};
            REG_ROW_Y: prdata = {1'b0, r_row_y};
            REG_ROW_W: prdata = {1'b0, r_row_w};
            default:   prdata = '0;
        endcase
    end

    // Global advance: the pipe moves whenever the output slot is free or drained
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // Stage A: products and constant terms per axis
    logic  r_va;
    t_prod r_px [NUM_AXES];
    t_prod r_py [NUM_AXES];
    t_sum  r_pc [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_px[a] <= t_prod'(t_coef'(r_row_x[a*COEF_BITS +: COEF_BITS]))
                         * t_prod'(i_point_x);
                r_py[a] <= t_prod'(t_coef'(r_row_y[a*COEF_BITS +: COEF_BITS]))
                         * t_prod'(i_point_y);
                r_pc[a] <= t_sum'(t_coef'(r_row_w[a*COEF_BITS +: COEF_BITS])) <<< COORD_FRAC;
            end
        end
    end

    // Stage B: sums xp, yp, z
    logic r_vb;
    t_sum r_s [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_s[a] <= t_sum'(r_px[a]) + t_sum'(r_py[a]) + r_pc[a];
            end
        end
    end

    // Stage C (divider slot 0) and divide steps 1..STEPS.
    // Lane 0 is x, lane 1 is y; both share the divisor magnitude.
    logic r_vd   [STEPS+1];
    logic r_zero [STEPS+1];
    t_mag r_den  [STEPS+1];
    logic r_neg  [STEPS+1][2];
    logic r_ovf  [STEPS+1][2];
    t_mag r_rem  [STEPS+1][2];
    t_quo r_dq   [STEPS+1][2];

    t_mag n_den;
    t_mag n_an  [2];
    t_mag n_rem [STEPS+1][2];
    t_quo n_dq  [STEPS+1][2];
    logic [MAG_W:0] n_trial [STEPS+1][2];

    always_comb begin
        n_den = t_mag'(r_s[2][SUM_W-1] ? -r_s[2] : r_s[2]);
        for (int l = 0; l < 2; l++) begin
            n_an[l]       = t_mag'(r_s[l][SUM_W-1] ? -r_s[l] : r_s[l]);
            n_rem[0][l]   = n_an[l] >> OUT_FRAC;
            n_dq[0][l]    = {n_an[l][OUT_FRAC-1:0], {(OUT_W-OUT_FRAC){1'b0}}};
            n_trial[0][l] = '0;
        end
        for (int k = 1; k <= STEPS; k++) begin
            for (int l = 0; l < 2; l++) begin
                n_trial[k][l] = {r_rem[k-1][l], r_dq[k-1][l][OUT_W-1]};
                if (n_trial[k][l] >= {1'b0, r_den[k-1]}) begin
                    n_rem[k][l] = t_mag'(n_trial[k][l] - {1'b0, r_den[k-1]});
                    n_dq[k][l]  = {r_dq[k-1][l][OUT_W-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = t_mag'(n_trial[k][l]);
                    n_dq[k][l]  = {r_dq[k-1][l][OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else if (en) begin
            r_vd[0] <= r_vb;
            for (int k = 1; k <= STEPS; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= (r_s[2] == '0);
            r_den[0]  <= n_den;
            for (int l = 0; l < 2; l++) begin
                r_neg[0][l] <= r_s[l][SUM_W-1] ^ r_s[2][SUM_W-1];
                // quotient needs more than OUT_W bits when an >= den * 2^OUT_FRAC
                r_ovf[0][l] <= {{OUT_FRAC{1'b0}}, n_an[l]} >= {n_den, {OUT_FRAC{1'b0}}};
                r_rem[0][l] <= n_rem[0][l];
                r_dq[0][l]  <= n_dq[0][l];
            end
            for (int k = 1; k <= STEPS; k++) begin
                r_zero[k] <= r_zero[k-1];
                r_den[k]  <= r_den[k-1];
                for (int l = 0; l < 2; l++) begin
                    r_neg[k][l] <= r_neg[k-1][l];
                    r_ovf[k][l] <= r_ovf[k-1][l];
                    r_rem[k][l] <= n_rem[k][l];
                    r_dq[k][l]  <= n_dq[k][l];
                end
            end
        end
    end

    // Output stage: apply sign, clamp, and zero-divisor override
    logic [OUT_W-1:0] n_res [2];
    logic             n_sat [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (!r_neg[STEPS][l]) begin
                n_sat[l] = r_ovf[STEPS][l] | r_dq[STEPS][l][OUT_W-1];
                n_res[l] = n_sat[l] ? POS_MAX : r_dq[STEPS][l];
            end else begin
                n_sat[l] = r_ovf[STEPS][l] | (r_dq[STEPS][l] > NEG_MIN);
                n_res[l] = n_sat[l] ? NEG_MIN : -r_dq[STEPS][l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= r_vd[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_zero[STEPS]) begin
                o_out_x        <= '0;
                o_out_y        <= '0;
                o_zero_divisor <= 1'b1;
                o_saturated    <= 1'b0;
            end else begin
                o_out_x        <= n_res[0];
                o_out_y        <= n_res[1];
                o_zero_divisor <= 1'b0;
                o_saturated    <= n_sat[0] | n_sat[1];
            end
        end
    end

    // Checks on the datapath
    `HPT2D_ASSERT_SAME(a_zero_clean, i_clk, i_rst_n, o_valid && o_zero_divisor,
        o_out_x == '0 && o_out_y == '0 && !o_saturated)
    `HPT2D_ASSERT_SAME(a_sat_extreme, i_clk, i_rst_n, o_valid && o_saturated,
        o_out_x == POS_MAX || o_out_x == NEG_MIN || o_out_y == POS_MAX || o_out_y == NEG_MIN)
    `HPT2D_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_va)
    `HPT2D_ASSERT_NEXT(a_stall_holds_tail, i_clk, i_rst_n, !en,
        $stable(r_vd[STEPS]) && $stable(r_dq[STEPS][0]))

endmodule
